// ----- hw/rtl/ppmdec_pkg.sv -----
// Shared types, codes and defaults for the PPM P6 stream decoder.
package ppmdec_pkg;

	localparam int MAX_DIM_DEF   = 4096;
	localparam int FRAC_BITS_DEF = 14;
	localparam int QDEPTH        = 4;

	localparam logic [1:0] KIND_SAMPLE    = 2'd0;
	localparam logic [1:0] KIND_BAD_HDR   = 2'd1;
	localparam logic [1:0] KIND_TRUNCATED = 2'd2;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_EOS  = 1'b1;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_COMMENT,
		PH_TOKEN,
		PH_PIXELS,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [23:0] sample_value;
		logic [11:0]        column;
		logic [11:0]        row;
		logic [1:0]         channel;
		logic               last_sample;
	} out_beat_t;

	// One classified work item handed from the parser to the divider side.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] max_value;
		logic [11:0] column;
		logic [11:0] row;
		logic [1:0]  channel;
		logic        last_sample;
	} cmd_t;

endpackage

// ----- hw/rtl/ppmdec_front.sv -----
// Header parser and pixel cursor: turns stream bytes into queued work items.
module ppmdec_front
	import ppmdec_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_beat_t beat,
	output logic     cmd_valid,
	output cmd_t     cmd
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] MAG_NONE = 2'd0;
	localparam logic [1:0] MAG_P    = 2'd1;
	localparam logic [1:0] MAG_OK   = 2'd2;
	localparam logic [1:0] MAG_BAD  = 2'd3;

	localparam logic [16:0] ACC_SAT = 17'd65536;

	typedef struct packed {
		logic [1:0]  magic;
		logic [16:0] acc;
		logic        started;
		logic        neg;
		logic        stopped;
	} tok_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic tok_t tok_char(input tok_t t, input logic [1:0] num,
		input logic [7:0] b);
		tok_t        r;
		logic        skip;
		logic [20:0] v;
		r    = t;
		skip = 1'b0;
		v    = 21'(t.acc) * 21'd10 + 21'(b - CH_ZERO);
		if (num == 2'd0) begin
			case (t.magic)
				MAG_NONE: r.magic = (b == CH_P) ? MAG_P : MAG_BAD;
				MAG_P:    r.magic = (b == CH_SIX) ? MAG_OK : MAG_BAD;
				default:  r.magic = MAG_BAD;
			endcase
		end else if (!t.stopped) begin
			if (!t.started) begin
				r.started = 1'b1;
				if (b == CH_MINUS) begin
					r.neg = 1'b1;
					skip  = 1'b1;
				end else if (b == CH_PLUS) begin
					skip = 1'b1;
				end
			end
			if (!skip) begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					r.acc = (v > 21'(ACC_SAT)) ? ACC_SAT : v[16:0];
				end else begin
					r.stopped = 1'b1;
				end
			end
		end
		return r;
	endfunction

	phase_t             phase_q, phase_d;
	logic [1:0]         num_q, num_d;
	tok_t               tok_q, tok_d;
	logic [DIM_W-1:0]   width_q, width_d;
	logic [DIM_W-1:0]   height_q, height_d;
	logic [15:0]        maxv_q, maxv_d;
	logic [DIM_W-1:0]   cx_q, cx_d;
	logic [DIM_W-1:0]   cy_q, cy_d;
	logic [1:0]         ch_q, ch_d;

	tok_t       tok_in;
	tok_t       tok_new;
	logic       tok_ok;
	logic       last_x;
	logic       last_y;
	logic       last_px;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			num_q    <= 2'd0;
			tok_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			maxv_q   <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			ch_q     <= 2'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			num_q    <= num_d;
			tok_q    <= tok_d;
			width_q  <= width_d;
			height_q <= height_d;
			maxv_q   <= maxv_d;
			cx_q     <= cx_d;
			cy_q     <= cy_d;
			ch_q     <= ch_d;
		end
	end

	// A token opened from the skip phase starts from a cleared token state.
	assign tok_in  = (phase_q == PH_SKIP) ? tok_t'('0) : tok_q;
	assign tok_new = tok_char(tok_in, num_q, beat.data_byte);

	always_comb begin
		if (num_q == 2'd0) begin
			tok_ok = (tok_q.magic == MAG_OK);
		end else if (tok_q.neg || tok_q.acc < 17'd1 || tok_q.acc > 17'd65535) begin
			tok_ok = 1'b0;
		end else if (num_q != 2'd3) begin
			tok_ok = (tok_q.acc <= 17'(MAX_DIM));
		end else begin
			tok_ok = 1'b1;
		end
	end

	assign last_x  = ({1'b0, cx_q} + 1'b1) >= {1'b0, width_q};
	assign last_y  = ({1'b0, cy_q} + 1'b1) >= {1'b0, height_q};
	assign last_px = (ch_q == 2'd2) && last_x && last_y;

	always_comb begin
		phase_d   = phase_q;
		num_d     = num_q;
		tok_d     = tok_q;
		width_d   = width_q;
		height_d  = height_q;
		maxv_d    = maxv_q;
		cx_d      = cx_q;
		cy_d      = cy_q;
		ch_d      = ch_q;
		cmd_valid = 1'b0;
		cmd       = '0;
		if (beat.action == ACT_EOS) begin
			// Restart the parser; report a cut-off image.
			phase_d  = PH_SKIP;
			num_d    = 2'd0;
			tok_d    = '0;
			width_d  = '0;
			height_d = '0;
			maxv_d   = '0;
			cx_d     = '0;
			cy_d     = '0;
			ch_d     = 2'd0;
			if (phase_q != PH_DONE && phase_q != PH_ERROR) begin
				cmd_valid = 1'b1;
				cmd.kind  = KIND_TRUNCATED;
			end
		end else begin
			case (phase_q)
				PH_SKIP: begin
					if (beat.data_byte == CH_HASH) begin
						phase_d = PH_COMMENT;
					end else if (!is_ws(beat.data_byte)) begin
						phase_d = PH_TOKEN;
						tok_d   = tok_new;
					end
				end
				PH_COMMENT: begin
					if (beat.data_byte == CH_LF) begin
						phase_d = PH_SKIP;
					end
				end
				PH_TOKEN: begin
					if (!is_ws(beat.data_byte)) begin
						tok_d = tok_new;
					end else if (!tok_ok) begin
						phase_d   = PH_ERROR;
						cmd_valid = 1'b1;
						cmd.kind  = KIND_BAD_HDR;
					end else begin
						tok_d = '0;
						case (num_q)
							2'd1:    width_d  = tok_q.acc[DIM_W-1:0];
							2'd2:    height_d = tok_q.acc[DIM_W-1:0];
							2'd3:    maxv_d   = tok_q.acc[15:0];
							default: ;
						endcase
						if (num_q == 2'd3) begin
							phase_d = PH_PIXELS;
							cx_d    = '0;
							cy_d    = '0;
							ch_d    = 2'd0;
						end else begin
							phase_d = PH_SKIP;
							num_d   = num_q + 2'd1;
						end
					end
				end
				PH_PIXELS: begin
					cmd_valid       = 1'b1;
					cmd.kind        = KIND_SAMPLE;
					cmd.data_byte   = beat.data_byte;
					cmd.max_value   = maxv_q;
					cmd.column      = 12'(cx_q);
					cmd.row         = 12'(cy_q);
					cmd.channel     = ch_q;
					cmd.last_sample = last_px;
					if (last_px) begin
						phase_d = PH_DONE;
					end else if (ch_q != 2'd2) begin
						ch_d = ch_q + 2'd1;
					end else begin
						ch_d = 2'd0;
						if (!last_x) begin
							cx_d = cx_q + 1'b1;
						end else begin
							cx_d = '0;
							cy_d = cy_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/ppmdec_queue.sv -----
// Small FIFO of work items between the parser and the divider side.
module ppmdec_queue
	import ppmdec_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t pop_data,
	output logic full,
	output logic empty
);

	localparam int PW = $clog2(QDEPTH);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign full     = (cnt_q == (PW + 1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/ppmdec_back.sv -----
// Sample normalizer: bit-serial divide by maxval and result output register.
module ppmdec_back
	import ppmdec_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  cmd_t      q_data,
	output logic      q_pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_beat_t res_beat
);

	localparam int QW = FRAC_BITS + 9;
	localparam int CW = $clog2(QW);
	localparam int SW = (QW > 24) ? QW : 24;

	logic          busy_q;
	logic          fin_q;
	logic [CW-1:0] cnt_q;
	cmd_t          cur_q;
	logic [15:0]   mv_q;
	logic [15:0]   rem_q;
	logic [QW-1:0] qd_q;
	logic          out_valid_q;
	out_beat_t     out_q;

	logic [16:0]   r_ext;
	logic [16:0]   r_diff;
	logic          ge;
	logic [SW-1:0] q_ext;
	logic          out_free;
	logic          emit;

	assign r_ext  = {rem_q, qd_q[QW-1]};
	assign r_diff = r_ext - {1'b0, mv_q};
	assign ge     = r_ext >= {1'b0, mv_q};
	assign q_ext  = SW'(qd_q) - (SW'(1) << FRAC_BITS);

	assign out_free = !out_valid_q || !res_stall;
	assign emit     = busy_q && fin_q && out_free;
	assign q_pop    = !busy_q && !q_empty;

	assign res_valid = out_valid_q;
	assign res_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				fin_q  <= (q_data.kind != KIND_SAMPLE);
				cnt_q  <= '0;
			end else if (busy_q && !fin_q) begin
				cnt_q <= cnt_q + 1'b1;
				fin_q <= (cnt_q == CW'(QW - 1));
			end else if (emit) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
			mv_q  <= (q_data.max_value == 16'd0) ? 16'd1 : q_data.max_value;
			rem_q <= '0;
			qd_q  <= {q_data.data_byte, 1'b0, {FRAC_BITS{1'b0}}};
		end else if (busy_q && !fin_q) begin
			rem_q <= ge ? r_diff[15:0] : r_ext[15:0];
			qd_q  <= {qd_q[QW-2:0], ge};
		end
		if (emit) begin
			out_q.kind <= cur_q.kind;
			if (cur_q.kind == KIND_SAMPLE) begin
				out_q.sample_value <= q_ext[23:0];
				out_q.column       <= cur_q.column;
				out_q.row          <= cur_q.row;
				out_q.channel      <= cur_q.channel;
				out_q.last_sample  <= cur_q.last_sample;
			end else begin
				out_q.sample_value <= '0;
				out_q.column       <= '0;
				out_q.row          <= '0;
				out_q.channel      <= '0;
				out_q.last_sample  <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/ppm_rgb_stream_decoder_top.sv -----
// Top level of the PPM P6 stream decoder: parser, work queue and divider side.
// The parser takes a byte every cycle while the work queue has room. The bit-serial
// divider works on one pixel sample at a time and does not take the next one before
// it is through; each sample takes FRAC_BITS+9 steps plus load and output, which sets
// the sustained sample rate.
// arst_n clears parser phase, queue pointers and output valid; the block is ready at once.
module ppm_rgb_stream_decoder_top
	import ppmdec_pkg::*;
#(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_beat_t  byte_beat,
	output logic      result_valid,
	input  logic      result_stall,
	output out_beat_t result_beat
);

	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t q_data;

	// Hold the byte stream whenever the queue cannot take another item; every
	// byte beat makes at most one item, so a free slot is all the parser needs.
	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;

	// Front: classify bytes, track header tokens and the pixel cursor.
	ppmdec_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.beat     (byte_beat),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	// Queue: decouple the one-byte-per-cycle parser (while not stalled) from the slow divider.
	ppmdec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && cmd_valid),
		.push_data(cmd),
		.pop      (q_pop),
		.pop_data (q_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back: normalize samples against maxval and drive the result register.
	ppmdec_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.res_valid(result_valid),
		.res_stall(result_stall),
		.res_beat (result_beat)
	);

endmodule
